[src/hdht_pkg.sv]
// shared types and constants of the host name hash table
package hdht_pkg;

	localparam int CFG_W = 11;
	localparam int MUL_PRIMARY = 17;
	localparam int MUL_STEP = 239;
	localparam int SIZE_RESET = 991;
	localparam int SIZE_MIN = 3;

	typedef enum logic [2:0] {
		ST_FOUND     = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

endpackage

[src/hdht_if.sv]
// request and response channel interfaces of the host name hash table
interface hdht_req_if;
	logic        valid;
	logic        ready;
	logic [7:0]  name_byte;
	logic        last;
	logic [31:0] ip;

	modport source (output valid, name_byte, last, ip, input ready);
	modport sink (input valid, name_byte, last, ip, output ready);
endinterface

interface hdht_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] ip_res;

	modport source (output valid, status, ip_res, input ready);
	modport sink (input valid, status, ip_res, output ready);
endinterface

[src/hdht_ram.sv]
// generic simple dual port ram with registered read
module hdht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/hostname_double_hash_table_top.sv]
// top level of the host name to address hash table with double hashing
//
// Host names arrive one byte per request; the request with last set carries
// the address to insert (zero means lookup only) and yields one response.
// Each stored byte updates both running hashes, which are then reduced in
// parallel by restoring remainder steps, one bit per cycle: the primary
// modulo the table size, the step modulo one less. A byte past the name
// limit is dropped. The last byte of a name within the limit then probes
// the table bucket by bucket: a metadata read and check per bucket, a byte
// by byte name compare in a bucket of equal length, a byte by byte copy on
// insert, then the response once the output register is free. Bucket
// metadata lives in one ram and the stored name bytes in another, both
// read in the cycle after the address. After reset a clearing pass empties
// all buckets; no request is taken meanwhile, configuration writes are.
module hostname_double_hash_table_top #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int NAME_BYTES = 127
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [hdht_pkg::CFG_W-1:0] cfg_data,
	hdht_req_if.sink                  req,
	hdht_rsp_if.source                rsp
);
	localparam int HW = $clog2(TABLE_ENTRIES);
	localparam int SW = $clog2(TABLE_ENTRIES + 1);
	localparam int LW = $clog2(NAME_BYTES + 1);
	localparam int PAW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
	localparam int NAW = $clog2(TABLE_ENTRIES * NAME_BYTES);
	localparam int VW = $clog2(hdht_pkg::MUL_STEP * TABLE_ENTRIES + 256);
	localparam int CW = $clog2(VW + 1);
	localparam int META_W = 1 + LW + 32;
	localparam int RST_SIZE = (hdht_pkg::SIZE_RESET > TABLE_ENTRIES) ?
		TABLE_ENTRIES : hdht_pkg::SIZE_RESET;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DIV, S_P_RD, S_P_CHK, S_C_RD, S_C_CHK,
		S_I_RD, S_I_WR, S_RES
	} state_t;

	state_t              state_q;
	logic [SW-1:0]       size_q;
	logic [HW-1:0]       clr_q;
	logic [LW-1:0]       len_q;
	logic                ovf_q;
	logic [HW-1:0]       prim_q;
	logic [HW-1:0]       step_q;
	logic                last_q;
	logic [31:0]         ip_q;
	logic [VW-1:0]       v1_q;
	logic [VW-1:0]       v2_q;
	logic [SW-1:0]       rem1_q;
	logic [SW-1:0]       rem2_q;
	logic [CW-1:0]       cnt_q;
	logic [HW-1:0]       h_q;
	logic [HW-1:0]       stride_q;
	logic [SW-1:0]       n_q;
	logic [NAW-1:0]      base_q;
	logic [PAW-1:0]      j_q;
	hdht_pkg::status_t   st_q;
	logic [31:0]         res_ip_q;
	logic                ov_q;
	hdht_pkg::status_t   ost_q;
	logic [31:0]         oip_q;

	// ram ports
	logic                meta_we;
	logic [HW-1:0]       meta_waddr;
	logic [META_W-1:0]   meta_wdata;
	logic [META_W-1:0]   meta_rdata;
	logic                pend_we;
	logic [7:0]          pend_rdata;
	logic                name_we;
	logic [NAW-1:0]      name_addr;
	logic [7:0]          name_rdata;

	logic                accept;
	logic                store_byte;
	logic [SW:0]         sh1;
	logic [SW:0]         sh2;
	logic [SW:0]         d1;
	logic [SW:0]         d2;
	logic [HW:0]         h_sum;
	logic [HW-1:0]       h_next;
	logic                last_j;
	logic                m_valid;
	logic [LW-1:0]       m_len;
	logic [31:0]         m_ip;
	logic [31:0]         cfg_ext;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign store_byte = !ovf_q && (len_q < LW'(NAME_BYTES));

	assign m_valid = meta_rdata[META_W-1];
	assign m_len = meta_rdata[32 +: LW];
	assign m_ip = meta_rdata[31:0];

	// one restoring remainder step for each hash
	assign d1 = (SW + 1)'(size_q);
	assign d2 = (SW + 1)'(size_q) - (SW + 1)'(1);
	assign sh1 = {rem1_q, v1_q[VW-1]};
	assign sh2 = {rem2_q, v2_q[VW-1]};

	// next probe position with wrap at the table size
	assign h_sum = (HW + 1)'(h_q) + (HW + 1)'(stride_q);
	assign h_next = (h_sum >= (HW + 1)'(size_q)) ?
		HW'(h_sum - (HW + 1)'(size_q)) : HW'(h_sum);
	assign last_j = ((LW + 1)'(j_q) + (LW + 1)'(1)) == (LW + 1)'(len_q);

	assign cfg_ext = 32'(cfg_data);

	// ram write control
	always_comb begin
		meta_we = 1'b0;
		meta_waddr = h_q;
		meta_wdata = {1'b1, len_q, ip_q};
		if (state_q == S_CLR) begin
			meta_we = 1'b1;
			meta_waddr = clr_q;
			meta_wdata = '0;
		end else if (state_q == S_P_CHK && !m_valid && ip_q != 32'd0) begin
			meta_we = 1'b1;
		end
	end

	assign pend_we = accept && store_byte;
	assign name_we = (state_q == S_I_WR);
	assign name_addr = base_q + NAW'(j_q);

	hdht_ram #(.WIDTH(META_W), .DEPTH(TABLE_ENTRIES)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (h_q),
		.rdata (meta_rdata)
	);

	hdht_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_pend (
		.clk   (clk),
		.we    (pend_we),
		.waddr (PAW'(len_q)),
		.wdata (req.name_byte),
		.raddr (j_q),
		.rdata (pend_rdata)
	);

	hdht_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES * NAME_BYTES)) u_name (
		.clk   (clk),
		.we    (name_we),
		.waddr (name_addr),
		.wdata (pend_rdata),
		.raddr (name_addr),
		.rdata (name_rdata)
	);

	// control sequencer, hash state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			size_q <= SW'(RST_SIZE);
			clr_q <= '0;
			len_q <= '0;
			ovf_q <= 1'b0;
			prim_q <= '0;
			step_q <= '0;
			ov_q <= 1'b0;
			last_q <= 1'b0;
			cnt_q <= '0;
			n_q <= '0;
			j_q <= '0;
			h_q <= '0;
		end else begin
			// configuration write with clamping
			if (cfg_we) begin
				if (cfg_ext < 32'(hdht_pkg::SIZE_MIN)) begin
					size_q <= SW'(hdht_pkg::SIZE_MIN);
				end else if (cfg_ext > 32'(TABLE_ENTRIES)) begin
					size_q <= SW'(TABLE_ENTRIES);
				end else begin
					size_q <= SW'(cfg_ext);
				end
			end

			// response handed over with no new one to load
			if (rsp.valid && rsp.ready && state_q != S_RES) begin
				ov_q <= 1'b0;
			end

			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + HW'(1);
					if (clr_q == HW'(TABLE_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						last_q <= req.last;
						ip_q <= req.ip;
						st_q <= hdht_pkg::ST_TOO_LONG;
						res_ip_q <= '0;
						if (store_byte) begin
							len_q <= len_q + LW'(1);
							v1_q <= VW'(prim_q) * VW'(hdht_pkg::MUL_PRIMARY)
								+ VW'(req.name_byte);
							v2_q <= VW'(step_q) * VW'(hdht_pkg::MUL_STEP)
								+ VW'(req.name_byte);
							rem1_q <= '0;
							rem2_q <= '0;
							cnt_q <= '0;
							state_q <= S_DIV;
						end else begin
							ovf_q <= 1'b1;
							if (req.last) begin
								state_q <= S_RES;
							end
						end
					end
				end
				S_DIV: begin
					rem1_q <= (sh1 >= d1) ? SW'(sh1 - d1) : SW'(sh1);
					rem2_q <= (sh2 >= d2) ? SW'(sh2 - d2) : SW'(sh2);
					v1_q <= v1_q << 1;
					v2_q <= v2_q << 1;
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(VW - 1)) begin
						prim_q <= (sh1 >= d1) ? HW'(sh1 - d1) : HW'(sh1);
						step_q <= (sh2 >= d2) ? HW'(sh2 - d2) : HW'(sh2);
						if (last_q) begin
							h_q <= (sh1 >= d1) ? HW'(sh1 - d1) : HW'(sh1);
							stride_q <= ((sh2 >= d2) ? HW'(sh2 - d2) : HW'(sh2))
								+ HW'(1);
							n_q <= '0;
							state_q <= S_P_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_P_RD: begin
					state_q <= S_P_CHK;
				end
				S_P_CHK: begin
					base_q <= NAW'(h_q) * NAW'(NAME_BYTES);
					j_q <= '0;
					if (!m_valid) begin
						if (ip_q != 32'd0) begin
							st_q <= hdht_pkg::ST_INSERTED;
							res_ip_q <= ip_q;
							state_q <= S_I_RD;
						end else begin
							st_q <= hdht_pkg::ST_NOT_FOUND;
							state_q <= S_RES;
						end
					end else if (m_len == len_q) begin
						res_ip_q <= m_ip;
						state_q <= S_C_RD;
					end else if (n_q + SW'(1) == size_q) begin
						st_q <= hdht_pkg::ST_FULL;
						state_q <= S_RES;
					end else begin
						h_q <= h_next;
						n_q <= n_q + SW'(1);
						state_q <= S_P_RD;
					end
				end
				S_C_RD: begin
					state_q <= S_C_CHK;
				end
				S_C_CHK: begin
					if (name_rdata != pend_rdata) begin
						// mismatch, move to the next bucket
						res_ip_q <= '0;
						if (n_q + SW'(1) == size_q) begin
							st_q <= hdht_pkg::ST_FULL;
							state_q <= S_RES;
						end else begin
							h_q <= h_next;
							n_q <= n_q + SW'(1);
							state_q <= S_P_RD;
						end
					end else if (last_j) begin
						st_q <= hdht_pkg::ST_FOUND;
						state_q <= S_RES;
					end else begin
						j_q <= j_q + PAW'(1);
						state_q <= S_C_RD;
					end
				end
				S_I_RD: begin
					state_q <= S_I_WR;
				end
				S_I_WR: begin
					if (last_j) begin
						state_q <= S_RES;
					end else begin
						j_q <= j_q + PAW'(1);
						state_q <= S_I_RD;
					end
				end
				S_RES: begin
					if (!ov_q || rsp.ready) begin
						ov_q <= 1'b1;
						ost_q <= st_q;
						oip_q <= res_ip_q;
						len_q <= '0;
						ovf_q <= 1'b0;
						prim_q <= '0;
						step_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.status = ost_q;
	assign rsp.ip_res = oip_q;

	// a found or inserted answer always carries a real address
	a_res_ip: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == hdht_pkg::ST_FOUND ||
		rsp.status == hdht_pkg::ST_INSERTED) |-> rsp.ip_res != 32'd0)
		else $error("found or inserted response with zero address");

	// probing stays inside the buckets in use
	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_P_CHK |-> (SW + 1)'(h_q) < (SW + 1)'(size_q))
		else $error("probe position beyond table size");

	// a new response leaves the pending name cleared
	a_pending_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> len_q == '0 && !ovf_q && prim_q == '0)
		else $error("pending name not cleared after response");
endmodule

[tb/hostname_double_hash_table_top_test.sv]
// testbench for the host name hash table: random byte requests checked against a predictor
module hostname_double_hash_table_top_test;

	localparam int DEPTH = 1024;
	localparam int NAME_MAX = 127;
	localparam int LIMIT_CYCLES = 3000000;

	typedef struct packed {
		logic [7:0]  name_byte;
		logic        last;
		logic [31:0] ip;
	} byte_req_t;

	typedef struct packed {
		hdht_pkg::status_t status;
		logic [31:0]       ip_res;
	} lookup_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [hdht_pkg::CFG_W-1:0] cfg_data = '0;

	hdht_req_if req ();
	hdht_rsp_if rsp ();

	hostname_double_hash_table_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.req(req), .rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	int unsigned tbl_size;
	bit          bkt_valid [DEPTH];
	logic [31:0] bkt_addr [DEPTH];
	int unsigned bkt_len [DEPTH];
	logic [7:0]  bkt_name [DEPTH][NAME_MAX];
	logic [7:0]  cur_name [NAME_MAX];
	int unsigned cur_len;
	int unsigned cur_h1;
	int unsigned cur_step;
	bit          cur_overflow;

	byte_req_t   pending_reqs[$];
	lookup_rsp_t expected_rsps[$];
	int          errors = 0;
	bit          calm = 1'b0;
	int unsigned sent = 0;

	// names known to be stored, for repeat lookups
	logic [7:0]  known_names[$][$];

	function automatic int unsigned clamp_size(int unsigned v);
		if (v < hdht_pkg::SIZE_MIN) return hdht_pkg::SIZE_MIN;
		if (v > DEPTH) return DEPTH;
		return v;
	endfunction

	function automatic void predict_byte(byte_req_t r);
		int unsigned h, stride, n;
		hdht_pkg::status_t st;
		logic [31:0] res;
		bit same;
		if (!cur_overflow) begin
			if (cur_len < NAME_MAX) begin
				cur_name[cur_len] = r.name_byte;
				cur_len++;
				cur_h1 = (cur_h1 * hdht_pkg::MUL_PRIMARY + r.name_byte) % tbl_size;
				cur_step = (cur_step * hdht_pkg::MUL_STEP + r.name_byte) % (tbl_size - 1);
			end else begin
				cur_overflow = 1'b1;
			end
		end
		if (!r.last) return;
		res = '0;
		if (cur_overflow) begin
			st = hdht_pkg::ST_TOO_LONG;
		end else begin
			h = cur_h1 % tbl_size;
			stride = cur_step % (tbl_size - 1) + 1;
			st = hdht_pkg::ST_FULL;
			for (n = 0; n < tbl_size; n++) begin
				if (!bkt_valid[h]) begin
					if (r.ip != 0) begin
						bkt_valid[h] = 1'b1;
						bkt_addr[h] = r.ip;
						bkt_len[h] = cur_len;
						for (int i = 0; i < cur_len; i++) bkt_name[h][i] = cur_name[i];
						st = hdht_pkg::ST_INSERTED;
						res = r.ip;
					end else begin
						st = hdht_pkg::ST_NOT_FOUND;
					end
					break;
				end
				same = (bkt_len[h] == cur_len);
				for (int i = 0; same && i < cur_len; i++)
					if (bkt_name[h][i] != cur_name[i]) same = 1'b0;
				if (same) begin
					st = hdht_pkg::ST_FOUND;
					res = bkt_addr[h];
					break;
				end
				h += stride;
				if (h >= tbl_size) h -= tbl_size;
			end
		end
		cur_len = 0;
		cur_h1 = 0;
		cur_step = 0;
		cur_overflow = 1'b0;
		expected_rsps.push_back('{st, res});
	endfunction

	// queue one name, byte by byte
	task automatic queue_name(input logic [7:0] nm[$], input logic [31:0] addr);
		byte_req_t r;
		for (int i = 0; i < nm.size(); i++) begin
			r.name_byte = nm[i];
			r.last = (i == nm.size() - 1);
			r.ip = r.last ? addr : $urandom;
			pending_reqs.push_back(r);
		end
	endtask

	function automatic void random_name(output logic [7:0] nm[$], input int len);
		nm = {};
		for (int i = 0; i < len; i++) nm.push_back($urandom_range(0, 255));
	endfunction

	task automatic drain();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_size(input int unsigned v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v[hdht_pkg::CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		tbl_size = clamp_size(v);
	endtask

	// one phase of random traffic
	task automatic random_phase(input int count);
		logic [7:0] nm[$];
		int len, sel;
		for (int k = 0; k < count; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 30 && known_names.size() != 0) begin
				nm = known_names[$urandom_range(0, known_names.size() - 1)];
				queue_name(nm, ($urandom_range(0, 1) != 0) ? $urandom : 32'd0);
			end else if (sel < 33) begin
				random_name(nm, $urandom_range(128, 140));
				queue_name(nm, $urandom);
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 127)
					: $urandom_range(1, 4);
				random_name(nm, len);
				if ($urandom_range(0, 3) == 0) begin
					queue_name(nm, 32'd0);
				end else begin
					queue_name(nm, $urandom);
					known_names.push_back(nm);
				end
			end
		end
	endtask

	// stimulus and configuration phases
	initial begin
		logic [7:0] nm[$];
		tbl_size = hdht_pkg::SIZE_RESET;
		cur_len = 0; cur_h1 = 0; cur_step = 0; cur_overflow = 0;
		foreach (bkt_valid[i]) bkt_valid[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every status but full
		nm = {8'h00}; queue_name(nm, 32'd0);
		nm = {8'h00}; queue_name(nm, 32'hFFFF_FFFF); known_names.push_back(nm);
		nm = {8'h00}; queue_name(nm, 32'd1);
		nm = {8'hFF}; queue_name(nm, 32'h8000_0000);
		nm = {8'hFF, 8'h00, 8'hAA, 8'h55}; queue_name(nm, 32'h1234_5678);
		nm = {8'hFF, 8'h00, 8'hAA, 8'h55}; queue_name(nm, 32'd0);
		random_name(nm, 127); queue_name(nm, 32'hCAFE_0001);
		queue_name(nm, 32'd0);
		random_name(nm, 128); queue_name(nm, 32'hDEAD_0001);
		random_name(nm, 1); queue_name(nm, 32'd0);
		drain();

		// tiny table to force full
		write_size(3);
		random_phase(8);
		drain();
		write_size(0);
		random_phase(6);
		drain();
		write_size(2047);
		random_phase(8);
		drain();
		write_size(1024);
		random_phase(6);
		drain();
		write_size(7);
		random_phase(6);
		drain();
		// non-prime size with short stride cycles
		write_size(12);
		random_phase(6);
		drain();
		write_size(13);
		random_phase(6);
		drain();
		write_size(991);
		random_phase(5);
		drain();
		write_size(101);
		random_phase(5);
		calm = 1'b1;
		random_phase(5);
		drain();
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// request driver
	int req_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.name_byte <= '0;
			req.last <= 1'b0;
			req.ip <= '0;
		end else begin
			if (req.valid && req.ready) begin
				predict_byte(pending_reqs.pop_front());
				sent++;
			end
			if (req_gap > 0) begin
				req_gap <= req_gap - 1;
				req.valid <= 1'b0;
			end else if (!(req.valid && !req.ready)) begin
				if (!calm && $urandom_range(0, 19) == 0) begin
					req_gap <= $urandom_range(1, 17) - 1;
					req.valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					req.valid <= 1'b1;
					{req.name_byte, req.last, req.ip} <= pending_reqs[0];
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor with random back-pressure
	int rsp_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		lookup_rsp_t exp_r;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected response status=%0d ip_res=%h", rsp.status, rsp.ip_res);
					errors++;
				end else begin
					exp_r = expected_rsps.pop_front();
					if (rsp.status !== exp_r.status) begin
						$error("status expected %0d actual %0d", exp_r.status, rsp.status);
						errors++;
					end
					if (rsp.ip_res !== exp_r.ip_res) begin
						$error("ip_res expected %h actual %h", exp_r.ip_res, rsp.ip_res);
						errors++;
					end
				end
			end
			if (rsp_gap > 0) begin
				rsp_gap <= rsp_gap - 1;
				rsp.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				rsp_gap <= $urandom_range(1, 17) - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// watchdog
	int unsigned cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule

[hostname_double_hash_table_top.f]
src/hdht_pkg.sv
src/hdht_if.sv
src/hdht_ram.sv
src/hostname_double_hash_table_top.sv
tb/hostname_double_hash_table_top_test.sv
